[design/multi_stack_shared_pool_defines.svh]
// Assertion macros shared by the multi_stack_shared_pool RTL.
`ifndef MULTI_STACK_SHARED_POOL_DEFINES_SVH
`define MULTI_STACK_SHARED_POOL_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/msp_pkg.sv]
// Package with types and constants of the shared-pool multi-stack block.
package msp_pkg;

  localparam int STACKS_DEF  = 8;
  localparam int SLOTS_DEF   = 64;
  localparam int STACK_IDX_W = 3;
  localparam int VALUE_W     = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_UPDATE
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch request, read stack top
    logic fetch;    // read link and data of the selected slot
    logic update;   // write back and load the result register
  } ctl_t;

endpackage

[design/msp_ctrl.sv]
// Controller state machine sequencing one request through fetch and update.
`include "multi_stack_shared_pool_defines.svh"

module msp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output msp_pkg::ctl_t ctl
);
  import msp_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_FETCH;
      end
      ST_FETCH: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        // hold until the result register can take the answer
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    ctl.capture = 1'b0;
    ctl.fetch   = 1'b0;
    ctl.update  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        ctl.capture = s_tvalid;
      end
      ST_FETCH: begin
        ctl.fetch = 1'b1;
      end
      ST_UPDATE: begin
        ctl.update = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.update) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  `MSP_ASSERT_NEXT(a_accept_to_fetch, s_tvalid && s_tready, state == ST_FETCH,
    "accepted transfer did not move to fetch")
  `MSP_ASSERT_NOW(a_no_overwrite, ctl.update, !m_tvalid || m_tready,
    "result register overwritten while a transfer waits")
  `MSP_ASSERT_NEXT(a_update_completes, ctl.update, m_tvalid && state == ST_IDLE,
    "update did not present a result and return to idle")

endmodule

[design/msp_datapath.sv]
// Datapath: stack tops, slot link and data memories, free list and result register.
`include "multi_stack_shared_pool_defines.svh"

module msp_datapath #(
  parameter int STACKS = msp_pkg::STACKS_DEF,
  parameter int SLOTS  = msp_pkg::SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  msp_pkg::ctl_t                    ctl,
  input  logic [msp_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic [msp_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import msp_pkg::*;

  localparam int LINK_W = $clog2(SLOTS + 1);
  localparam int SLOT_AW = $clog2(SLOTS);
  localparam int STK_AW = (STACKS > 1) ? $clog2(STACKS) : 1;
  localparam int IDX_EXT_W = 9;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOTS);
  localparam logic [LINK_W-1:0] LINK_ONE = LINK_W'(1);
  localparam int OUT_PAD_W = OUT_TDATA_W - VALUE_W - 1;

  // incoming fields
  op_t                    in_cmd;
  logic [STACK_IDX_W-1:0] in_idx;
  logic [VALUE_W-1:0]     in_value;
  logic [IDX_EXT_W-1:0]   idx_ext;
  logic                   cap_in_range;
  logic [STK_AW-1:0]      cap_addr;

  assign in_cmd       = op_t'(s_tdata[0]);
  assign in_idx       = s_tdata[STACK_IDX_W:1];
  assign in_value     = s_tdata[STACK_IDX_W+VALUE_W:STACK_IDX_W+1];
  assign idx_ext      = IDX_EXT_W'(in_idx);
  assign cap_in_range = idx_ext < IDX_EXT_W'(STACKS);
  assign cap_addr     = idx_ext[STK_AW-1:0];

  // request registers
  op_t               req_cmd;
  logic              req_in_range;
  logic [STK_AW-1:0] req_addr;
  logic [VALUE_W-1:0] req_value;

  // state
  logic [LINK_W-1:0] free_head;
  logic [LINK_W-1:0] fill;       // slots at or above this were never linked
  logic [STACKS-1:0] top_valid;
  logic [LINK_W-1:0] top_mem [STACKS];
  logic [LINK_W-1:0] link_mem [SLOTS];
  logic [VALUE_W-1:0] data_mem [SLOTS];

  // read registers
  logic [LINK_W-1:0]  top_rd;
  logic               top_rd_valid;
  logic [LINK_W-1:0]  link_rd;
  logic [VALUE_W-1:0] data_rd;
  logic [LINK_W-1:0]  slot_q;
  logic [LINK_W-1:0]  top_q;
  logic               slot_ok_q;
  logic               fresh_q;

  // fetch-stage selection
  logic [LINK_W-1:0]  top_eff;
  logic [LINK_W-1:0]  slot_sel;
  logic               slot_ok;
  logic [SLOT_AW-1:0] fetch_addr;
  logic [SLOT_AW-1:0] upd_addr;
  logic [LINK_W-1:0]  link_eff;
  logic               do_push;
  logic               do_pop;

  assign top_eff    = top_rd_valid ? top_rd : NULL_LINK;
  assign slot_sel   = (req_cmd == CMD_POP) ? top_eff : free_head;
  assign slot_ok    = req_in_range && (slot_sel < NULL_LINK);
  assign fetch_addr = slot_sel[SLOT_AW-1:0];
  assign upd_addr   = slot_q[SLOT_AW-1:0];
  // a slot never linked still points to the next one
  assign link_eff   = fresh_q ? (slot_q + LINK_ONE) : link_rd;
  assign do_push    = ctl.update && slot_ok_q && (req_cmd == CMD_PUSH);
  assign do_pop     = ctl.update && slot_ok_q && (req_cmd == CMD_POP);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      req_cmd      <= in_cmd;
      req_in_range <= cap_in_range;
      req_addr     <= cap_addr;
      req_value    <= in_value;
    end
  end

  // stack top memory, entries without a valid bit read as empty
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      top_rd       <= top_mem[cap_addr];
      top_rd_valid <= cap_in_range && top_valid[cap_addr];
    end
    if (do_push) begin
      top_mem[req_addr] <= slot_q;
    end else if (do_pop) begin
      top_mem[req_addr] <= link_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_valid <= '0;
    end else if (do_push || do_pop) begin
      top_valid[req_addr] <= 1'b1;
    end
  end

  // slot link and data memories
  always_ff @(posedge clk) begin
    if (ctl.fetch && slot_ok) begin
      link_rd <= link_mem[fetch_addr];
      data_rd <= data_mem[fetch_addr];
    end
    if (do_push) begin
      link_mem[upd_addr] <= top_q;
      data_mem[upd_addr] <= req_value;
    end else if (do_pop) begin
      link_mem[upd_addr] <= free_head;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fetch) begin
      slot_q    <= slot_sel;
      top_q     <= top_eff;
      slot_ok_q <= slot_ok;
      fresh_q   <= slot_sel >= fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= '0;
      fill      <= '0;
    end else if (do_push) begin
      free_head <= link_eff;
      if (fresh_q) fill <= fill + LINK_ONE;
    end else if (do_pop) begin
      free_head <= slot_q;
    end
  end

  // result register
  logic               out_ok;
  logic [VALUE_W-1:0] out_value;

  always_ff @(posedge clk) begin
    if (ctl.update) begin
      out_ok    <= slot_ok_q;
      out_value <= do_pop ? data_rd : '0;
    end
  end

  assign m_tdata = {OUT_PAD_W'(0), out_value, out_ok};

  `MSP_ASSERT_NOW(a_head_in_range, 1'b1, free_head <= NULL_LINK && fill <= NULL_LINK,
    "free head or fill mark beyond the pool")
  `MSP_ASSERT_NOW(a_fresh_only_push, ctl.update && slot_ok_q && fresh_q,
    req_cmd == CMD_PUSH, "pop reached a slot that was never linked")
  `MSP_ASSERT_NEXT(a_push_moves_head, do_push, free_head != $past(free_head),
    "push did not advance the free head")

endmodule

[design/multi_stack_shared_pool.sv]
// Several LIFO stacks sharing one slot pool through a free list.
//
// Input channel s_*: one transfer is a push or a pop on one stack. A push
// takes the free-list head slot, stores push_value and makes it the stack top;
// a pop returns the top value and puts its slot back on the free list.
// Output channel m_*: exactly one transfer per request. ok=1 when the push
// was stored or the pop found an element; ok=0 when the pool is full, the
// stack is empty or the stack number is out of range (nothing changes then).
// pop_value is the popped value on a successful pop and 0 otherwise.
// Each request is handled alone, through the chain stack top read, then
// slot link/data read, then write back; the next request is accepted only
// after that write back. All three stores are single-port memories with
// registered reads.
// Reset: all stacks empty, free list holds every slot in order; ready
// right after reset, no clearing pass.
// Stall: a held result does not block acceptance of the next request; the
// write back of that request waits until the result register is free.
module multi_stack_shared_pool #(
  parameter int STACKS = msp_pkg::STACKS_DEF,
  parameter int SLOTS  = msp_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // cmd[0], stack_index[3:1], push_value[35:4], zero fill[39:36]
  input  logic [msp_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // ok[0], pop_value[32:1], zero fill[39:33]
  output logic [msp_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import msp_pkg::*;

  ctl_t ctl;

  msp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .ctl      (ctl)
  );

  msp_datapath #(
    .STACKS (STACKS),
    .SLOTS  (SLOTS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata)
  );

endmodule
